// ===== hdl/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the k-nearest-neighbor interpolator.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned KMax      = 16;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);
  localparam int unsigned KIdxW     = $clog2(KMax);
  localparam int unsigned KCntW     = $clog2(KMax + 1);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdLoad  = 2'd1,
    CmdQuery = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_z;
    logic [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] interp_value;
    logic        no_points;
  } out_item_t;

  // work item handed from the front part to the back part
  typedef struct packed {
    logic              empty;
    logic [CountW-1:0] count;
    logic [KCntW-1:0]  k;
    logic [31:0]       qx;
    logic [31:0]       qz;
  } job_t;

endpackage

// ===== hdl/knn_stream_if.sv =====
// ----------------------------------------------------------------------------
// knn_stream_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface knn_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/knn_ram.sv =====
// ----------------------------------------------------------------------------
// knn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/knn_front.sv =====
// ----------------------------------------------------------------------------
// knn_front
// Accepts commands, writes loads into the point store, queues query jobs.
// ----------------------------------------------------------------------------
module knn_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [4:0]                     cfg_wdata_i,
  knn_stream_if.sink                     in_if,
  output logic                           st_we_o,
  output logic [knn_pkg::AddrW-1:0]      st_waddr_o,
  output logic [95:0]                    st_wdata_o,
  output logic                           job_valid_o,
  output knn_pkg::job_t                  job_o,
  input  logic                           job_ready_i,
  input  logic                           back_busy_i
);
  logic [knn_pkg::CountW-1:0] count_q, count_d;
  logic [4:0]                 nc_q;
  knn_pkg::job_t              fifo_q [knn_pkg::QueueDepth];
  logic                       wp_q, rp_q;
  logic [1:0]                 fill_q;
  logic                       push, pop, full;
  logic [knn_pkg::KCntW-1:0]  k_sel;
  knn_pkg::job_t              job_new;

  assign full = (fill_q == 2'(knn_pkg::QueueDepth));
  // clear waits until no query still reads the store
  assign in_if.ready = !full && !((in_if.data.cmd == knn_pkg::CmdClear)
                                  && (job_valid_o || back_busy_i));
  assign push = in_if.valid && in_if.ready && (in_if.data.cmd == knn_pkg::CmdQuery);
  assign pop  = job_valid_o && job_ready_i;
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o = fifo_q[rp_q];

  always_comb begin
    priority if (nc_q == 5'd0) begin
      k_sel = knn_pkg::KCntW'(1);
    end else if (32'(nc_q) > knn_pkg::KMax) begin
      k_sel = knn_pkg::KCntW'(knn_pkg::KMax);
    end else begin
      k_sel = knn_pkg::KCntW'(nc_q);
    end
    job_new.empty = (count_q == '0);
    job_new.count = count_q;
    job_new.k     = (32'(k_sel) > 32'(count_q)) ? knn_pkg::KCntW'(count_q) : k_sel;
    job_new.qx    = in_if.data.pos_x;
    job_new.qz    = in_if.data.pos_z;
  end

  assign st_we_o = in_if.valid && in_if.ready && (in_if.data.cmd == knn_pkg::CmdLoad)
                   && (32'(count_q) < knn_pkg::MaxPoints);
  assign st_waddr_o = count_q[knn_pkg::AddrW-1:0];
  assign st_wdata_o = {in_if.data.pos_x, in_if.data.pos_z, in_if.data.sample_value};

  always_comb begin
    count_d = count_q;
    if (in_if.valid && in_if.ready) begin
      if (in_if.data.cmd == knn_pkg::CmdClear) begin
        count_d = '0;
      end else if (st_we_o) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      nc_q    <= 5'd4;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      fill_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        nc_q <= cfg_wdata_i;
      end
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= job_new;
    end
  end
endmodule

// ===== hdl/knn_back.sv =====
// ----------------------------------------------------------------------------
// knn_back
// Scans the store, keeps the k nearest, then weights and divides serially.
// ----------------------------------------------------------------------------
module knn_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  knn_pkg::job_t              job_i,
  output logic                       job_ready_o,
  output logic                       busy_o,
  output logic [knn_pkg::AddrW-1:0]  st_raddr_o,
  input  logic [95:0]                st_rdata_i,
  knn_stream_if.source               out_if
);
  typedef enum logic [3:0] {
    StIdle, StScan, StDiff, StSq, StIns, StShift, StAcc, StSqrt, StRecip,
    StMul, StDivH, StDivL, StOut
  } state_e;

  state_e                     state_q;
  knn_pkg::job_t              job_q;
  logic [knn_pkg::CountW-1:0] idx_q;
  logic [knn_pkg::CountW-1:0] slot_q;
  logic [63:0]                bd_q [knn_pkg::KMax];
  logic [knn_pkg::AddrW-1:0]  bs_q [knn_pkg::KMax];
  logic [knn_pkg::KCntW-1:0]  have_q, j_q, i_q;
  logic [32:0]                dx_q, dz_q;
  logic [63:0]                a_q, b_q, d2_q;
  logic                       rd_pend_q;
  // sqrt / divide scratch
  logic [63:0]                sn_q, sroot_q, sbit_q;
  logic [6:0]                 cnt_q;
  logic [64:0]                rem_q;
  logic [32:0]                dist_q;
  logic [32:0]                quo_q;
  logic [32:0]                w_q;
  logic [31:0]                v_q;
  logic [36:0]                wsum_q;
  logic signed [56:0]         sh_q;
  logic [56:0]                sl_q;
  logic [48:0]                wvl_q;
  logic signed [49:0]         wvh_q;
  logic signed [56:0]         qh_q;
  logic [56:0]                rh_q;
  logic [80:0]                dn_q;
  logic [56:0]                dq_q;
  logic [56:0]                dr_q;
  logic                       dneg_q;
  logic                       out_valid_q;
  knn_pkg::out_item_t         out_q;

  logic [32:0] dx_abs, dz_abs;
  logic [64:0] d2_sum;
  logic [63:0] sum_rb;
  logic [64:0] rem_try;
  logic [57:0] dr_try;
  logic signed [73:0] res_full;
  logic [56:0] sh_abs;
  logic [knn_pkg::KCntW-1:0] k_m1, j_m1, i_p1;

  assign job_ready_o = (state_q == StIdle) && !out_valid_q;
  assign busy_o = (state_q != StIdle);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  assign k_m1 = job_q.k - 1'b1;
  assign j_m1 = j_q - 1'b1;
  assign i_p1 = i_q + 1'b1;

  assign dx_abs = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
  assign dz_abs = dz_q[32] ? (~dz_q + 33'd1) : dz_q;
  assign d2_sum = {1'b0, a_q} + {1'b0, b_q};
  assign sum_rb = sroot_q + sbit_q;
  assign rem_try = {rem_q[63:0], (cnt_q == 7'd1)} - {32'd0, dist_q};
  assign dr_try = {dr_q, dn_q[80]} - {21'd0, wsum_q};
  assign sh_abs = sh_q[56] ? 57'(-sh_q) : 57'(sh_q);
  assign res_full = $signed({qh_q, 16'd0}) + $signed({1'b0, dq_q[15:0]})
                    + $signed({{17{1'b0}}, dq_q} - {17'd0, 41'd0, dq_q[15:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i && !out_valid_q) begin
            job_q <= job_i;
            if (job_i.empty) begin
              out_q.interp_value <= '0;
              out_q.no_points    <= 1'b1;
              out_valid_q        <= 1'b1;
            end else begin
              for (int n = 0; n < knn_pkg::KMax; n++) begin
                bd_q[n] <= '1;
              end
              idx_q     <= '0;
              have_q    <= '0;
              rd_pend_q <= 1'b0;
              state_q   <= StScan;
            end
          end
        end
        StScan: begin
          // issue read through the registered address; StDiff waits on rd_pend_q for the RAM's registered data
          st_raddr_o <= idx_q[knn_pkg::AddrW-1:0];
          slot_q     <= idx_q;
          idx_q      <= idx_q + 1'b1;
          state_q    <= StDiff;
          rd_pend_q  <= 1'b1;
        end
        StDiff: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else begin
            dx_q    <= {st_rdata_i[95], st_rdata_i[95:64]} - {job_q.qx[31], job_q.qx};
            dz_q    <= {st_rdata_i[63], st_rdata_i[63:32]} - {job_q.qz[31], job_q.qz};
            state_q <= StSq;
          end
        end
        StSq: begin
          a_q     <= 64'(dx_abs * dx_abs);
          b_q     <= 64'(dz_abs * dz_abs);
          state_q <= StIns;
        end
        StIns: begin
          d2_q <= d2_sum[64] ? '1 : d2_sum[63:0];
          if (have_q == job_q.k && (d2_sum[64] ? '1 : d2_sum[63:0])
              >= bd_q[k_m1[knn_pkg::KIdxW-1:0]]) begin
            state_q <= StAcc;
          end else begin
            if (have_q < job_q.k) begin
              j_q    <= have_q;
              have_q <= have_q + 1'b1;
            end else begin
              j_q <= k_m1;
            end
            state_q <= StShift;
          end
        end
        StShift: begin
          if (j_q != '0 && bd_q[j_m1[knn_pkg::KIdxW-1:0]] > d2_q) begin
            bd_q[j_q[knn_pkg::KIdxW-1:0]] <= bd_q[j_m1[knn_pkg::KIdxW-1:0]];
            bs_q[j_q[knn_pkg::KIdxW-1:0]] <= bs_q[j_m1[knn_pkg::KIdxW-1:0]];
            j_q <= j_m1;
          end else begin
            bd_q[j_q[knn_pkg::KIdxW-1:0]] <= d2_q;
            bs_q[j_q[knn_pkg::KIdxW-1:0]] <= slot_q[knn_pkg::AddrW-1:0];
            state_q <= StAcc;
          end
        end
        StAcc: begin
          if (state_q == StAcc && idx_q != job_q.count) begin
            state_q <= StScan;
          end else begin
            i_q     <= '0;
            wsum_q  <= '0;
            sh_q    <= '0;
            sl_q    <= '0;
            sn_q    <= bd_q[0];
            sroot_q <= '0;
            sbit_q  <= 64'h4000_0000_0000_0000;
            cnt_q   <= '0;
            st_raddr_o <= bs_q[0];
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          // one bit pair per cycle
          if (sn_q >= sum_rb) begin
            sn_q    <= sn_q - sum_rb;
            sroot_q <= (sroot_q >> 1) + sbit_q;
          end else begin
            sroot_q <= sroot_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          if (sbit_q == 64'd1) begin
            state_q <= StRecip;
            cnt_q   <= '0;
            rem_q   <= '0;
            quo_q   <= '0;
            v_q     <= st_rdata_i[31:0];
          end
        end
        StRecip: begin
          if (cnt_q == 7'd0) begin
            dist_q <= 33'(sroot_q) + 33'd1;
            rem_q  <= '0;
            cnt_q  <= 7'd1;
          end else begin
            // restoring divide of 2^32 by dist, 33 quotient bits
            if (!rem_try[64] && ({rem_q[63:0], (cnt_q == 7'd1)} >= {32'd0, dist_q})) begin
              rem_q <= {1'b0, rem_try[63:0]};
              quo_q <= {quo_q[31:0], 1'b1};
            end else begin
              rem_q <= {rem_q[63:0], (cnt_q == 7'd1)};
              quo_q <= {quo_q[31:0], 1'b0};
            end
            if (cnt_q == 7'd33) begin
              state_q <= StMul;
              cnt_q   <= '0;
            end else begin
              cnt_q <= cnt_q + 7'd1;
            end
          end
        end
        StMul: begin
          if (cnt_q == 7'd0) begin
            w_q   <= quo_q;
            cnt_q <= 7'd1;
          end else if (cnt_q == 7'd1) begin
            wvl_q <= 49'(w_q * {17'd0, v_q[15:0]});
            wvh_q <= 50'($signed({1'b0, w_q}) * $signed(v_q[31:16]));
            cnt_q <= 7'd2;
          end else begin
            wsum_q <= wsum_q + 37'(w_q);
            sl_q   <= sl_q + 57'(wvl_q);
            sh_q   <= sh_q + 57'(wvh_q);
            cnt_q  <= '0;
            if (i_p1 == have_q) begin
              state_q <= StDivH;
              dneg_q  <= sh_q[56] ^ 1'b0;
            end else begin
              i_q        <= i_p1;
              sn_q       <= bd_q[i_p1[knn_pkg::KIdxW-1:0]];
              sroot_q    <= '0;
              sbit_q     <= 64'h4000_0000_0000_0000;
              st_raddr_o <= bs_q[i_p1[knn_pkg::KIdxW-1:0]];
              state_q    <= StSqrt;
            end
          end
        end
        StDivH: begin
          // floor(sh / wsum) via magnitude division
          if (cnt_q == 7'd0) begin
            dneg_q <= sh_q[56];
            dn_q   <= {sh_abs, 24'd0};
            dr_q   <= '0;
            dq_q   <= '0;
            cnt_q  <= 7'd1;
          end else begin
            if (!dr_try[57]) begin
              dr_q <= dr_try[56:0];
              dq_q <= {dq_q[55:0], 1'b1};
            end else begin
              dr_q <= {dr_q[55:0], dn_q[80]};
              dq_q <= {dq_q[55:0], 1'b0};
            end
            dn_q <= dn_q << 1;
            if (cnt_q == 7'd57) begin
              cnt_q   <= '0;
              state_q <= StDivL;
            end else begin
              cnt_q <= cnt_q + 7'd1;
            end
          end
        end
        StDivL: begin
          if (cnt_q == 7'd0) begin
            if (dneg_q) begin
              if (dr_q != '0) begin
                qh_q <= -$signed(dq_q) - 57'sd1;
                rh_q <= 57'(wsum_q) - dr_q;
              end else begin
                qh_q <= -$signed(dq_q);
                rh_q <= '0;
              end
            end else begin
              qh_q <= $signed(dq_q);
              rh_q <= dr_q;
            end
            cnt_q <= 7'd1;
          end else if (cnt_q == 7'd1) begin
            dn_q  <= {(rh_q << 16) + sl_q, 24'd0};
            dr_q  <= '0;
            dq_q  <= '0;
            cnt_q <= 7'd2;
          end else begin
            if (!dr_try[57]) begin
              dr_q <= dr_try[56:0];
              dq_q <= {dq_q[55:0], 1'b1};
            end else begin
              dr_q <= {dr_q[55:0], dn_q[80]};
              dq_q <= {dq_q[55:0], 1'b0};
            end
            dn_q <= dn_q << 1;
            if (cnt_q == 7'd58) begin
              cnt_q   <= '0;
              state_q <= StOut;
            end else begin
              cnt_q <= cnt_q + 7'd1;
            end
          end
        end
        StOut: begin
          if (!out_valid_q) begin
            out_q.no_points <= 1'b0;
            if (res_full > 74'sd2147483647) begin
              out_q.interp_value <= 32'h7fff_ffff;
            end else if (res_full < -74'sd2147483648) begin
              out_q.interp_value <= 32'h8000_0000;
            end else begin
              out_q.interp_value <= res_full[31:0];
            end
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== hdl/knn_inverse_distance_interpolator_top.sv =====
// query steps: take the job, scan every stored point (with shift steps when a point enters
// the nearest list), then sqrt, reciprocal and multiply per neighbor, and a final divide;
// one query in the back at a time
// a clear waits until no query is queued or running
// reset clears the point count and sets neighbor_count to 4; store is not cleared
// ----------------------------------------------------------------------------
// knn_inverse_distance_interpolator_top
// k-nearest-neighbor inverse-distance interpolator over a stored point set.
// ----------------------------------------------------------------------------
module knn_inverse_distance_interpolator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  knn_stream_if.sink   in_if,
  knn_stream_if.source out_if
);
  logic                      st_we;
  logic [knn_pkg::AddrW-1:0] st_waddr, st_raddr;
  logic [95:0]               st_wdata, st_rdata;
  logic                      job_valid, job_ready, back_busy;
  knn_pkg::job_t             job;

  knn_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_if,
    .st_we_o(st_we), .st_waddr_o(st_waddr), .st_wdata_o(st_wdata),
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready),
    .back_busy_i(back_busy)
  );

  knn_ram #(.Width(96), .Depth(knn_pkg::MaxPoints)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  knn_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .busy_o(back_busy),
    .st_raddr_o(st_raddr), .st_rdata_i(st_rdata),
    .out_if
  );

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> 32'(job.k) <= knn_pkg::KMax) else $error("k out of range");
  a_empty_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job.empty |-> job.k != '0) else $error("zero k on nonempty store");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
endmodule
